// ===== rtl/core/qcfs_pkg.sv =====
// Shared types and codes for the quoted CSV field splitter.
// Used by qcfs_step and quoted_csv_field_splitter; no dependencies.
`default_nettype none

package qcfs_pkg;

    localparam int unsigned CHAR_W = 8;

    // Register reset values
    localparam logic [CHAR_W-1:0] QUOTE_RESET = 8'd34;  // double quote
    localparam logic [CHAR_W-1:0] DELIM_RESET = 8'd44;  // comma

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_QUOTE = 1'b0,
        CFG_DELIM = 1'b1
    } t_cfg_idx;

    // Parser mode; codes 6 and 7 behave as dropping
    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_PLAIN   = 3'd1,
        MODE_QUOTED  = 3'd2,
        MODE_PLAIN_Q = 3'd3,
        MODE_QUOTE_Q = 3'd4,
        MODE_DROP    = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_UNEXP_QUOTE = 2'd0,
        ERR_NO_CLOSE    = 2'd1,
        ERR_EXP_DELIM   = 2'd2
    } t_err;

    // One result transaction
    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [CHAR_W-1:0] data;
        t_err              err;
        logic              last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/qcfs_step.sv =====
// Per-character parse step: next mode and the optional result.
// Depends on qcfs_pkg.
`default_nettype none

module qcfs_step
    import qcfs_pkg::*;
(
    input  wire t_mode             i_mode,
    input  wire logic [CHAR_W-1:0] i_char,
    input  wire logic              i_eot,
    input  wire logic [CHAR_W-1:0] i_quote,
    input  wire logic [CHAR_W-1:0] i_delim,
    output t_mode                  o_mode,
    output t_result                o_res
);

    logic is_q;
    logic is_d;

    // Quote wins when quote and delimiter are equal
    assign is_q = !i_eot && (i_char == i_quote);
    assign is_d = !i_eot && !is_q && (i_char == i_delim);

    // Next mode
    always_comb begin
        o_mode = i_eot ? MODE_START : i_mode;
        unique case (i_mode)
            MODE_START: begin
                if (is_q) begin
                    o_mode = MODE_QUOTED;
                end else if (!i_eot && !is_d) begin
                    o_mode = MODE_PLAIN;
                end
            end
            MODE_PLAIN: begin
                if (is_q) begin
                    o_mode = MODE_PLAIN_Q;
                end else if (is_d) begin
                    o_mode = MODE_START;
                end
            end
            MODE_QUOTED: begin
                if (is_q) begin
                    o_mode = MODE_QUOTE_Q;
                end
            end
            MODE_PLAIN_Q: begin
                if (is_q) begin
                    o_mode = MODE_PLAIN;
                end else if (!i_eot) begin
                    o_mode = MODE_DROP;
                end
            end
            MODE_QUOTE_Q: begin
                if (is_q) begin
                    o_mode = MODE_QUOTED;
                end else if (is_d) begin
                    o_mode = MODE_START;
                end else if (!i_eot) begin
                    o_mode = MODE_DROP;
                end
            end
            default: begin
                if (!i_eot) begin
                    o_mode = MODE_DROP;
                end
            end
        endcase
    end

    // Result; line_started only matters for an end item at field start
    always_comb begin
        o_res = '{valid: 1'b0, kind: KIND_DATA, data: '0, err: ERR_UNEXP_QUOTE, last: 1'b0};
        unique case (i_mode)
            MODE_START: begin
                if (is_d) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_END;
                end else if (!i_eot && !is_q) begin
                    o_res.valid = 1'b1;
                    o_res.data  = i_char;
                end
            end
            MODE_PLAIN: begin
                if (i_eot || is_d) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_END;
                    o_res.last  = i_eot;
                end else if (!is_q) begin
                    o_res.valid = 1'b1;
                    o_res.data  = i_char;
                end
            end
            MODE_QUOTED: begin
                if (i_eot) begin
                    o_res.valid = 1'b1;
                    o_res.kind  = KIND_ERR;
                    o_res.err   = ERR_NO_CLOSE;
                end else if (!is_q) begin
                    o_res.valid = 1'b1;
                    o_res.data  = i_char;
                end
            end
            MODE_PLAIN_Q: begin
                o_res.valid = 1'b1;
                if (is_q) begin
                    o_res.data = i_quote;
                end else begin
                    o_res.kind = KIND_ERR;
                    o_res.err  = ERR_UNEXP_QUOTE;
                end
            end
            MODE_QUOTE_Q: begin
                o_res.valid = 1'b1;
                if (is_q) begin
                    o_res.data = i_quote;
                end else if (i_eot || is_d) begin
                    o_res.kind = KIND_END;
                    o_res.last = i_eot;
                end else begin
                    o_res.kind = KIND_ERR;
                    o_res.err  = ERR_EXP_DELIM;
                end
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/quoted_csv_field_splitter.sv =====
// Top level of the quoted CSV field splitter: input register, parse step, result register.
// Depends on qcfs_pkg and qcfs_step.
`default_nettype none

// Channel   Dir  tdata (low bit first)               tuser     tlast
// s_axis    in   char_in[7:0]                         -         end_of_text
// m_axis    out  data_byte[7:0], error_code[9:8], 0s  kind[1:0] last_field
// cfg       in   i_cfg_we / i_cfg_index / i_cfg_wdata (0 quote_char, 1 delimiter_char)
//
// One character per cycle while m_axis does not stall; a transaction passes the
// input register, then the result register. A transaction with no result still
// takes its slot in the result stage but shows nothing on m_axis.
// Synchronous active-low reset: parser at field start, line not started, quote 34,
// delimiter 44, both stages empty. A stall on m_axis holds the result and, once
// the input register is full too, deasserts o_s_axis_tready.

module quoted_csv_field_splitter
    import qcfs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input characters
    input  wire logic              i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire logic [7:0]        i_s_axis_tdata,   // [7:0] char_in
    input  wire logic              i_s_axis_tlast,   // end_of_text
    // results
    output logic                   o_m_axis_tvalid,
    input  wire logic              i_m_axis_tready,
    output logic [15:0]            o_m_axis_tdata,   // [7:0] data_byte, [9:8] error_code
    output logic [1:0]             o_m_axis_tuser,   // [1:0] kind
    output logic                   o_m_axis_tlast,   // last_field
    // configuration
    input  wire logic              i_cfg_we,
    input  wire t_cfg_idx          i_cfg_index,
    input  wire logic [CHAR_W-1:0] i_cfg_wdata
);

    // Config registers
    logic [CHAR_W-1:0] r_quote;
    logic [CHAR_W-1:0] r_delim;

    // Input stage
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_eot;

    // Parser state
    t_mode             r_mode;
    logic              r_started;
    t_mode             n_mode;

    // Result stage
    t_result           r_out;
    t_result           n_res;

    logic              out_free;
    logic              advance;
    logic              in_take;

    assign out_free        = !r_out.valid || i_m_axis_tready;
    assign advance         = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote <= QUOTE_RESET;
            r_delim <= DELIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_QUOTE: r_quote <= i_cfg_wdata;
                CFG_DELIM: r_delim <= i_cfg_wdata;
                default:   r_quote <= r_quote;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_s_axis_tdata;
            r_in_eot  <= i_s_axis_tlast;
        end
    end

    qcfs_step u_step (
        .i_mode  (r_mode),
        .i_char  (r_in_char),
        .i_eot   (r_in_eot),
        .i_quote (r_quote),
        .i_delim (r_delim),
        .o_mode  (n_mode),
        .o_res   (n_res)
    );

    // Parser state advances with each character leaving the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_START;
            r_started <= 1'b0;
        end else if (advance) begin
            r_mode    <= n_mode;
            r_started <= !r_in_eot;
        end
    end

    // Result register; an end item at field start closes a field only if
    // the line has seen a character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (advance) begin
            r_out.valid <= n_res.valid
                || (r_in_eot && r_started && (r_mode == MODE_START));
        end else if (i_m_axis_tready) begin
            r_out.valid <= 1'b0;
        end
        if (advance) begin
            if (r_in_eot && (r_mode == MODE_START)) begin
                r_out.kind <= KIND_END;
                r_out.data <= '0;
                r_out.err  <= ERR_UNEXP_QUOTE;
                r_out.last <= 1'b1;
            end else begin
                r_out.kind <= n_res.kind;
                r_out.data <= n_res.data;
                r_out.err  <= n_res.err;
                r_out.last <= n_res.last;
            end
        end
    end

    assign o_m_axis_tvalid = r_out.valid;
    assign o_m_axis_tdata  = {6'd0, r_out.err, r_out.data};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;

endmodule

`default_nettype wire

// ===== verif/quoted_csv_field_splitter_tb.sv =====
// Self-checking testbench for quoted_csv_field_splitter: a line parser predictor checks every
// result transaction. Uses qcfs_pkg for the register index, kind and error enums.
`timescale 1ns / 100ps

module quoted_csv_field_splitter_tb
    import qcfs_pkg::*;
();

    localparam int unsigned IDLE_PCT     = 21;    // chance of a gap on either side
    localparam int unsigned HOLD_CYCLES  = 150;   // long m_axis hold-off
    localparam int unsigned SETTLE       = 4;     // pipeline is two deep
    localparam int unsigned WDOG_LIMIT   = 2000;  // cycles with no transaction at all

    // One pending input transaction
    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } t_char_item;

    // Result as it appears on m_axis: {tuser, tdata, tlast}
    typedef struct packed {
        t_kind      kind;
        logic [5:0] pad;
        t_err       err;
        logic [7:0] data;
        logic       last;
    } t_field_event;

    // DUT ports; the inputs are known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata = '0;      // [7:0] char_in
    logic        i_s_axis_tlast = 1'b0;    // end_of_text
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;           // [7:0] data_byte, [9:8] error_code, rest zero
    logic [1:0]  o_m_axis_tuser;           // [1:0] kind
    logic        o_m_axis_tlast;           // last_field
    logic        i_cfg_we = 1'b0;
    t_cfg_idx    i_cfg_index = CFG_QUOTE;
    logic [7:0]  i_cfg_wdata = '0;

    // Stimulus and scoreboard storage
    t_char_item   char_q[$];          // characters waiting for the driver
    t_field_event field_events_q[$];  // predicted results, oldest first
    int unsigned  items_queued = 0;
    int unsigned  mismatches = 0;
    int unsigned  idle_cycles = 0;

    // Idling controls, set from the sequence block
    bit          calm = 1'b0;         // no random gaps on either side while set
    int unsigned stall_req_n = 0;     // bumped to ask for one long hold-off
    int unsigned stall_seen_n = 0;
    int unsigned stall_left = 0;

    // Predictor state: its own copy of the registers and the parser
    logic [7:0] quote_byte = QUOTE_RESET;
    logic [7:0] delim_byte = DELIM_RESET;
    t_mode      line_mode = MODE_START;
    bit         line_open = 1'b0;

    quoted_csv_field_splitter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Advances the line parser by one character transaction. Returns 1 when the
    // transaction produces a result, which is then left in ev.
    function automatic bit parse_byte(input logic [7:0] c, input logic eot,
                                      output t_field_event ev);
        bit    is_q;
        bit    is_d;
        bit    was_open;
        bit    has_result;
        t_mode cur;
        is_q       = !eot && (c == quote_byte);
        is_d       = !eot && !is_q && (c == delim_byte);  // quote wins when equal
        cur        = line_mode;
        was_open   = line_open;
        has_result = 1'b1;
        ev         = '{kind: KIND_DATA, pad: '0, err: ERR_UNEXP_QUOTE, data: '0, last: 1'b0};

        // every end item returns to field start, any character opens the line
        if (eot) begin
            line_mode = MODE_START;
            line_open = 1'b0;
        end else begin
            line_open = 1'b1;
        end

        case (cur)
            MODE_START: begin
                if (eot) begin
                    has_result = was_open;      // empty line gives nothing
                    ev.kind    = KIND_END;
                    ev.last    = 1'b1;
                end else if (is_q) begin
                    line_mode  = MODE_QUOTED;
                    has_result = 1'b0;
                end else if (is_d) begin
                    ev.kind = KIND_END;         // empty field
                end else begin
                    line_mode = MODE_PLAIN;
                    ev.data   = c;
                end
            end
            MODE_PLAIN: begin
                if (eot) begin
                    ev.kind = KIND_END;
                    ev.last = 1'b1;
                end else if (is_q) begin
                    line_mode  = MODE_PLAIN_Q;
                    has_result = 1'b0;
                end else if (is_d) begin
                    line_mode = MODE_START;
                    ev.kind   = KIND_END;
                end else begin
                    ev.data = c;
                end
            end
            MODE_QUOTED: begin
                if (eot) begin
                    ev.kind = KIND_ERR;         // end inside quotes
                    ev.err  = ERR_NO_CLOSE;
                end else if (is_q) begin
                    line_mode  = MODE_QUOTE_Q;
                    has_result = 1'b0;
                end else begin
                    ev.data = c;
                end
            end
            MODE_PLAIN_Q: begin
                if (is_q) begin
                    line_mode = MODE_PLAIN;
                    ev.data   = quote_byte;
                end else begin
                    // lone quote in an unquoted field
                    ev.kind = KIND_ERR;
                    ev.err  = ERR_UNEXP_QUOTE;
                    if (!eot)
                        line_mode = MODE_DROP;
                end
            end
            MODE_QUOTE_Q: begin
                if (is_q) begin
                    line_mode = MODE_QUOTED;
                    ev.data   = quote_byte;
                end else if (eot) begin
                    ev.kind = KIND_END;
                    ev.last = 1'b1;
                end else if (is_d) begin
                    line_mode = MODE_START;
                    ev.kind   = KIND_END;
                end else begin
                    // junk after the closing quote
                    ev.kind   = KIND_ERR;
                    ev.err    = ERR_EXP_DELIM;
                    line_mode = MODE_DROP;
                end
            end
            default: begin
                if (!eot)
                    line_mode = MODE_DROP;
                has_result = 1'b0;
            end
        endcase
        return has_result;
    endfunction

    // Driver: predicts on each accepted transaction, then offers the next pending one
    always @(posedge i_clk) begin
        t_char_item   nxt;
        t_field_event ev;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                if (parse_byte(i_s_axis_tdata, i_s_axis_tlast, ev))
                    field_events_q.insert(field_events_q.size(), ev);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (char_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    nxt = char_q[0];
                    char_q.delete(0);
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= nxt.ch;
                    i_s_axis_tlast  <= nxt.eot;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (stall_seen_n != stall_req_n) begin
            stall_seen_n    <= stall_req_n;
            stall_left      <= HOLD_CYCLES;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: every result transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_field_event seen;
        t_field_event want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen = {o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast};
            if (field_events_q.size() == 0) begin
                mismatches++;
                $display("%0t: expected none, actual kind %0d data %02h err %0d last %0d",
                         $time, seen.kind, seen.data, seen.err, seen.last);
            end else begin
                want = field_events_q[0];
                field_events_q.delete(0);
                if (seen !== want) begin
                    mismatches++;
                    $display("%0t: expected kind %0d data %02h err %0d last %0d pad %02h",
                             $time, want.kind, want.data, want.err, want.last, want.pad);
                    $display("%0t: actual   kind %0d data %02h err %0d last %0d pad %02h",
                             $time, seen.kind, seen.data, seen.err, seen.last, seen.pad);
                end
            end
        end
    end

    // Watchdog: a run of cycles with no transaction on either side is a hang
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                     || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_char(input logic [7:0] c);
        char_q.insert(char_q.size(), '{ch: c, eot: 1'b0});
        items_queued++;
    endtask

    // char_in is don't-care on the end item, so it carries a random byte
    task automatic push_end();
        char_q.insert(char_q.size(), '{ch: 8'($urandom_range(0, 255)), eot: 1'b1});
        items_queued++;
    endtask

    // Byte that is neither the quote nor the delimiter
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        while (b == quote_byte || b == delim_byte)
            b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    // Well-formed line with random content: quoted and unquoted fields,
    // doubled quotes, literal delimiters inside quotes, sometimes a trailing delimiter
    task automatic push_line();
        int unsigned nf;
        int unsigned len;
        bit          quoted;
        nf = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
        for (int unsigned f = 0; f < nf; f++) begin
            quoted = $urandom_range(0, 1);
            len    = $urandom_range(0, 5);
            if (quoted)
                push_char(quote_byte);
            for (int unsigned k = 0; k < len; k++) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        // doubled quote; not at the very start of an unquoted field
                        if (quoted || k != 0) begin
                            push_char(quote_byte);
                            push_char(quote_byte);
                        end else begin
                            push_char(plain_byte());
                        end
                    end
                    2: push_char(quoted ? delim_byte : plain_byte());
                    default: push_char(plain_byte());
                endcase
            end
            if (quoted)
                push_char(quote_byte);
            if (f + 1 < nf)
                push_char(delim_byte);
        end
        if (nf != 0 && $urandom_range(0, 9) == 0)
            push_char(delim_byte);
        push_end();
    endtask

    // Noise line: bytes biased toward quote and delimiter, then the end item
    task automatic push_noise();
        int unsigned len;
        len = $urandom_range(0, 8);
        for (int unsigned k = 0; k < len; k++) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4: push_char(quote_byte);
                5, 6, 7, 8:    push_char(delim_byte);
                default:       push_char(8'($urandom_range(0, 255)));
            endcase
        end
        push_end();
    endtask

    // Mostly well-formed lines, about a quarter noise
    task automatic push_random(input int unsigned n);
        int unsigned start;
        start = items_queued;
        while (items_queued - start < n) begin
            if ($urandom_range(0, 3) == 0)
                push_noise();
            else
                push_line();
        end
    endtask

    // Sender pause: wait until every queued character is in and every result is out,
    // then let the two pipeline stages empty
    task automatic drain();
        @(negedge i_clk);
        while (char_q.size() != 0 || i_s_axis_tvalid || field_events_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_QUOTE)
            quote_byte = value;
        else
            delim_byte = value;
    endtask

    // Sequence: reset, directed lines, then random phases over several register settings
    initial begin
        logic [7:0] q_set[5];
        logic [7:0] d_set[5];
        q_set = '{8'h00, 8'hFF, 8'd39, 8'h00, QUOTE_RESET};
        d_set = '{8'hFF, 8'h00, 8'd39, 8'h00, DELIM_RESET};
        // fourth setting is drawn at random, distinct bytes
        q_set[3] = 8'($urandom_range(0, 255));
        d_set[3] = 8'($urandom_range(0, 255));
        while (d_set[3] == q_set[3])
            d_set[3] = 8'($urandom_range(0, 255));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset registers
        push_end();                                  // empty line: nothing
        push_char(8'h00); push_char(8'hFF);          // zero byte is data, top byte
        push_char(delim_byte); push_end();           // last field end
        push_char(quote_byte); push_char(delim_byte);        // delimiter literal in quotes
        push_char(quote_byte); push_char(quote_byte);        // escaped quote
        push_char(quote_byte); push_end();                   // closing quote then end
        push_char(8'h61); push_char(quote_byte);
        push_char(quote_byte); push_char(delim_byte);        // escape in unquoted field
        push_end();                                          // trailing delimiter
        push_char(8'h62); push_char(quote_byte);
        push_char(delim_byte); push_char(8'h7A); push_end(); // lone quote, then dropping
        push_char(quote_byte); push_char(8'h6B); push_end(); // no closing quote
        push_char(quote_byte); push_char(quote_byte);
        push_char(8'h6D); push_end();                        // junk after closing quote
        drain();

        push_random(100);
        drain();
        push_random(100);
        drain();

        for (int p = 0; p < 5; p++) begin
            write_reg(CFG_QUOTE, q_set[p]);
            write_reg(CFG_DELIM, d_set[p]);
            calm = (p == 4);                         // long stretch with no random gaps
            push_random(110);
            if (p == 0 || p == 4)
                stall_req_n++;                       // fill the block, stall its input
            drain();
            calm = 1'b0;
            push_random(110);
            drain();
        end

        if (mismatches == 0 && field_events_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
